>>> src/aes_block_encrypt_assert.svh
`ifndef AES_BLOCK_ENCRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_ASSERT_SVH
// same-cycle implication, checked out of reset
`define AES_CHECK_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// next-cycle implication, checked out of reset
`define AES_CHECK_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

>>> src/aes_pkg.sv
package aes_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND
  } state_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_0    = 3'd1;
  localparam logic [2:0] REG_KEY_1    = 3'd2;
  localparam logic [2:0] REG_KEY_2    = 3'd3;
  localparam logic [2:0] REG_KEY_3    = 3'd4;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte n of the block sits at bits [127-8n -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

>>> src/aes_ram.sv
module aes_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/aes_block_encrypt.sv
// AES block encryption, 128/192/256-bit keys.
// Configuration: write_en/write_index/write_data; index 0 is key_size, 1..4
// are the key words. Every write taken while busy is low restarts round-key
// expansion, which yields 4*(Nr+1) words (44, 52 or 60) and keeps busy
// high; the same expansion runs after reset. Write only while busy is low.
// Input: plain_high/plain_low are taken at a clock edge with start high,
// busy low and write_en low. busy then stays high while the shared round
// unit runs one round per cycle, with round keys read from a 15-row key RAM
// one row ahead. Output: done pulses for one cycle with cipher_high and
// cipher_low after the final round. busy falls with done, so a new block
// may start in that same cycle. The receiver cannot stall: done is shown
// once, and cipher_high/cipher_low hold only until the next block ends.
// Reset: key registers clear to zero and the zero 128-bit key is expanded.
module aes_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [2:0]  write_index,
  input  logic [63:0] write_data,
  input  logic        start,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        busy,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low
);

  aes_pkg::state_t state, state_next;

  logic [1:0]   key_size;
  logic [63:0]  key_regs [4];
  logic [31:0]  win [8];
  logic [5:0]   widx;
  logic [2:0]   kidx;
  logic [7:0]   rc;
  logic [3:0]   round;
  logic [127:0] blk;

  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   wlast;
  logic [63:0]  key_sel;
  logic [31:0]  key_word;
  logic [31:0]  tmp;
  logic [31:0]  new_word;
  logic         ram_we;
  logic [3:0]   raddr;
  logic [127:0] rkey;
  logic [127:0] rnd_out;
  logic         start_ok;
  logic         expand_done;
  logic         last_round;

  always_comb begin
    unique case (key_size)
      aes_pkg::KEY_128: begin
        nk = 4'd4;
        nr = 4'd10;
      end
      aes_pkg::KEY_192: begin
        nk = 4'd6;
        nr = 4'd12;
      end
      default: begin
        nk = 4'd8;
        nr = 4'd14;
      end
    endcase
  end

  assign wlast       = {nr, 2'b11};
  assign start_ok    = start && !busy;
  assign expand_done = (state == aes_pkg::ST_EXPAND) && (widx == wlast);
  assign last_round  = (state == aes_pkg::ST_ROUND) && (round == nr);

  // key schedule: one word per cycle, last eight words held in win
  assign key_sel  = key_regs[widx[2:1]];
  assign key_word = widx[0] ? key_sel[31:0] : key_sel[63:32];

  always_comb begin
    tmp = win[7];
    if (kidx == 3'd0) begin
      tmp = aes_pkg::sub_word({win[7][23:0], win[7][31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kidx == 3'd4) begin
      tmp = aes_pkg::sub_word(win[7]);
    end
    if ({2'b00, widx} < {4'b0000, nk}) begin
      new_word = key_word;
    end else begin
      new_word = win[3'(4'd8 - nk)] ^ tmp;
    end
  end

  assign ram_we = (state == aes_pkg::ST_EXPAND) && (widx[1:0] == 2'b11);

  // fetch one row ahead; row 0 stays on the read port while idle
  always_comb begin
    raddr = 4'd0;
    if (state == aes_pkg::ST_ROUND && !last_round) begin
      raddr = round + 4'd1;
    end else if (state == aes_pkg::ST_IDLE && start_ok) begin
      raddr = 4'd1;
    end
  end

  aes_ram #(
    .WIDTH(128),
    .DEPTH(15)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx[5:2]),
    .wdata({win[5], win[6], win[7], new_word}),
    .raddr(raddr),
    .rdata(rkey)
  );

  always_comb begin
    rnd_out = aes_pkg::sub_shift(blk);
    if (!last_round) begin
      rnd_out = aes_pkg::mix_columns(rnd_out);
    end
    rnd_out = rnd_out ^ rkey;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aes_pkg::ST_IDLE: begin
        if (write_en) begin
          state_next = aes_pkg::ST_EXPAND;
        end else if (start) begin
          state_next = aes_pkg::ST_ROUND;
        end
      end
      aes_pkg::ST_EXPAND: begin
        if (expand_done) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      aes_pkg::ST_ROUND: begin
        if (last_round) begin
          state_next = aes_pkg::ST_IDLE;
        end
      end
      default: state_next = aes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != aes_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= aes_pkg::ST_EXPAND;
      key_size <= 2'd0;
      for (int k = 0; k < 4; k++) begin
        key_regs[k] <= '0;
      end
      widx  <= '0;
      kidx  <= '0;
      rc    <= 8'h01;
      round <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= last_round;
      if (write_en) begin
        unique case (write_index)
          aes_pkg::REG_KEY_SIZE: key_size    <= write_data[1:0];
          aes_pkg::REG_KEY_0:    key_regs[0] <= write_data;
          aes_pkg::REG_KEY_1:    key_regs[1] <= write_data;
          aes_pkg::REG_KEY_2:    key_regs[2] <= write_data;
          aes_pkg::REG_KEY_3:    key_regs[3] <= write_data;
          default: ;
        endcase
      end
      if (state == aes_pkg::ST_IDLE) begin
        widx  <= '0;
        kidx  <= '0;
        rc    <= 8'h01;
        round <= 4'd1;
      end else if (state == aes_pkg::ST_EXPAND) begin
        widx <= widx + 6'd1;
        kidx <= ({1'b0, kidx} == nk - 4'd1) ? 3'd0 : kidx + 3'd1;
        if (kidx == 3'd0 && {2'b00, widx} >= {4'b0000, nk}) begin
          rc <= aes_pkg::xtime(rc);
        end
      end else begin
        round <= round + 4'd1;
      end
    end
  end

  // an ignored write index does not change a key, so it still reruns harmlessly
  always_ff @(posedge clk) begin
    if (state == aes_pkg::ST_EXPAND) begin
      for (int k = 0; k < 7; k++) begin
        win[k] <= win[k + 1];
      end
      win[7] <= new_word;
    end
    if (state == aes_pkg::ST_IDLE) begin
      blk <= {plain_high, plain_low} ^ rkey;
    end else if (state == aes_pkg::ST_ROUND) begin
      blk <= rnd_out;
    end
    if (last_round) begin
      cipher_high <= rnd_out[127:64];
      cipher_low  <= rnd_out[63:0];
    end
  end

`include "aes_block_encrypt_assert.svh"

  `AES_CHECK_NEXT(a_start_runs, start_ok && !write_en, state == aes_pkg::ST_ROUND, "start did not begin rounds")
  `AES_CHECK_NOW(a_done_after_round, done, $past(state) == aes_pkg::ST_ROUND && !busy, "done without final round")
  `AES_CHECK_NOW(a_round_bound, state == aes_pkg::ST_ROUND, round >= 4'd1 && round <= nr, "round counter out of range")
  `AES_CHECK_NOW(a_expand_bound, state == aes_pkg::ST_EXPAND, widx <= wlast, "key schedule overran")

endmodule

>>> tb/sv/aes_block_encrypt_checker.sv
module aes_block_encrypt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [2:0]  write_index,
  input  logic [63:0] write_data,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  input  logic        done,
  input  logic [63:0] cipher_high,
  input  logic [63:0] cipher_low,
  output int          fail_count,
  output int          pending_count,
  output int          cipher_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [1:0]  size_reg;
  logic [63:0] key_reg [4];
  logic [31:0] round_words [60];
  block_t      cipher_queue [$];

  function automatic int nk_of(logic [1:0] sz);
    return sz == aes_pkg::KEY_128 ? 4 : (sz == aes_pkg::KEY_192 ? 6 : 8);
  endfunction

  function automatic logic [7:0] sb(logic [7:0] b);
    return aes_pkg::SBOX[b];
  endfunction

  function automatic logic [31:0] sub4(logic [31:0] w);
    return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
  endfunction

  task automatic build_schedule();
    int nk;
    logic [31:0] t;
    logic [63:0] r;
    nk = nk_of(size_reg);
    foreach (round_words[i]) round_words[i] = '0;
    for (int i = 0; i < 4 * (nk + 7); i++) begin
      if (i < nk) begin
        r = key_reg[(i >> 1) & 3];
        round_words[i] = (i & 1) ? r[31:0] : r[63:32];
      end else begin
        t = round_words[i - 1];
        if (i % nk == 0) begin
          t = sub4({t[23:0], t[31:24]});
          t ^= {RCON[(i / nk - 1) % 10], 24'h0};
        end else if (nk == 8 && i % nk == 4) begin
          t = sub4(t);
        end
        round_words[i] = round_words[i - nk] ^ t;
      end
    end
  endtask

  function automatic logic [127:0] add_key(logic [127:0] s, int rnd);
    return s ^ {round_words[4 * rnd], round_words[4 * rnd + 1],
                round_words[4 * rnd + 2], round_words[4 * rnd + 3]};
  endfunction

  function automatic logic [127:0] sub_rows(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8 * (4 * c + r) -: 8] = sb(s[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]);
    return t;
  endfunction

  function automatic logic [7:0] dbl(logic [7:0] b);
    return {b[6:0], 1'b0} ^ {3'b000, b[7], b[7], 1'b0, b[7], b[7]};
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[127 - 8 * (4 * c + r) -: 8];
      x = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int r = 0; r < 4; r++)
        t[127 - 8 * (4 * c + r) -: 8] = a[r] ^ x ^ dbl(a[r] ^ a[(r + 1) & 3]);
    end
    return t;
  endfunction

  function automatic block_t encrypt_block(logic [63:0] hi, logic [63:0] lo);
    logic [127:0] s;
    int nr;
    nr = nk_of(size_reg) + 6;
    s = add_key({hi, lo}, 0);
    for (int rnd = 1; rnd < nr; rnd++) s = add_key(mix_cols(sub_rows(s)), rnd);
    s = add_key(sub_rows(s), nr);
    return '{hi: s[127:64], lo: s[63:0]};
  endfunction

  always @(posedge clk) begin
    block_t exp_blk;
    if (rst) begin
      size_reg = aes_pkg::KEY_128;
      foreach (key_reg[i]) key_reg[i] = '0;
      build_schedule();
      cipher_queue.delete();
      fail_count = 0;
      pending_count = 0;
      cipher_count = 0;
    end else begin
      if (done) begin
        cipher_count++;
        if (cipher_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word %h %h", cipher_high, cipher_low);
        end else begin
          exp_blk = cipher_queue.pop_front();
          if (cipher_high !== exp_blk.hi || cipher_low !== exp_blk.lo) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cipher mismatch: exp %h %h got %h %h",
                       exp_blk.hi, exp_blk.lo, cipher_high, cipher_low);
          end
        end
      end
      if (start && !busy) cipher_queue.push_back(encrypt_block(plain_high, plain_low));
      if (write_en) begin
        if (write_index == aes_pkg::REG_KEY_SIZE) begin
          size_reg = write_data[1:0];
          build_schedule();
        end else if (write_index <= aes_pkg::REG_KEY_3) begin
          key_reg[write_index - 1] = write_data;
          build_schedule();
        end
      end
      pending_count = cipher_queue.size();
    end
  end
endmodule

>>> tb/sv/tb_aes_block_encrypt.sv
module tb_aes_block_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT = 400;
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        write_en;
  logic [2:0]  write_index;
  logic [63:0] write_data;
  logic        start;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic        busy;
  logic        done;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  int          fail_count;
  int          pending_count;
  int          cipher_count;
  int          idle_cycles;
  int          sent_count;
  logic        quiet_tail;

  aes_block_encrypt uut (.*);

  aes_block_encrypt_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: count cycles with no write, no accepted start and no done
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || write_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired");
        $display("tb_aes_block_encrypt: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    // wait for a full idle: expansion may still run after the last word
    do @(negedge clk); while (busy || pending_count != 0);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(negedge clk);
    write_en <= 1'b0;
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    // step off the edge where start was just dropped; busy is high there anyway
    if (!quiet_tail && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk);
    else
      @(negedge clk);
    start <= 1'b1;
    plain_high <= hi;
    plain_low <= lo;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
    sent_count++;
  endtask

  task automatic load_key(logic [1:0] sz, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(aes_pkg::REG_KEY_0, k0);
    write_reg(aes_pkg::REG_KEY_1, k1);
    write_reg(aes_pkg::REG_KEY_2, k2);
    write_reg(aes_pkg::REG_KEY_3, k3);
    write_reg(aes_pkg::REG_KEY_SIZE, {62'h0, sz});
  endtask

  initial begin
    logic [1:0] sz;
    rst = 1'b1;
    write_en = 1'b0;
    write_index = '0;
    write_data = '0;
    start = 1'b0;
    plain_high = '0;
    plain_low = '0;
    sent_count = 0;
    quiet_tail = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero key after reset, then the FIPS-197 example keys
    send_block('0, '0);
    send_block('1, '1);
    load_key(aes_pkg::KEY_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    load_key(aes_pkg::KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    load_key(aes_pkg::KEY_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('1, '0);
    // size code three acts as a 256-bit key
    write_reg(aes_pkg::REG_KEY_SIZE, 64'h3);
    send_block('0, '1);
    // out-of-range index is dropped
    write_reg(3'd5, rand64());
    write_reg(3'd7, '1);
    send_block(rand64(), rand64());
    load_key(aes_pkg::KEY_256, '1, '1, '1, '1);
    send_block('1, '1);
    load_key(aes_pkg::KEY_128, '0, '0, '0, '0);
    send_block(64'h8000000000000000, 64'h1);

    while (sent_count < ITEM_COUNT) begin
      if (sent_count > ITEM_COUNT - 60) quiet_tail = 1'b1;
      sz = 2'($urandom_range(0, 3));
      load_key(sz, rand64(), rand64(), rand64(), rand64());
      repeat ($urandom_range(10, 40)) send_block(rand64(), rand64());
    end

    do @(negedge clk); while (pending_count != 0 && idle_cycles < STALL_LIMIT);
    repeat (20) @(negedge clk);
    $display("sent %0d blocks, checked %0d cipher words over all key sizes",
             sent_count, cipher_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_aes_block_encrypt: PASS");
    end else begin
      $display("tb_aes_block_encrypt: FAIL");
    end
    $finish;
  end
endmodule
